@@ src/mre_pkg.sv @@
// shared types and constants for the mouse report encoder
`timescale 1ns / 1ps

package mre_pkg;

  // event field widths
  localparam int unsigned ButtonW = 7;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned ModW    = 8;
  localparam int unsigned CodeW   = 8;

  // decimal conversion: coordinate + 1 needs one more bit than the field
  localparam int unsigned ConvW    = CoordW + 1;
  localparam int unsigned NumDigits = 4;
  localparam int unsigned DigitIdxW = 2;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned ConvCntW  = 4;

  // which number of the report
  localparam int unsigned NumCode = 0;
  localparam int unsigned NumCol  = 1;
  localparam int unsigned NumRow  = 2;
  localparam int unsigned NumNums = 3;

  // code weights
  localparam logic [CodeW-1:0] MotionAdd = 8'd32;
  localparam logic [CodeW-1:0] ShiftAdd  = 8'd4;
  localparam logic [CodeW-1:0] AltAdd    = 8'd8;
  localparam logic [CodeW-1:0] CtrlAdd   = 8'd16;

  // modifier mask bits
  localparam int unsigned ModShiftBit = 0;
  localparam int unsigned ModCtrlBit  = 2;
  localparam int unsigned ModAltBit   = 3;

  // classic encoding
  localparam logic [CodeW-1:0]  ClassicCodeOfs  = 8'd32;
  localparam logic [CodeW-1:0]  ClassicCoordOfs = 8'd33;
  localparam logic [CoordW-1:0] ClassicClamp    = 12'd222;

  // report characters
  localparam logic [7:0] ChEsc     = 8'd27;
  localparam logic [7:0] ChBracket = 8'h5b;
  localparam logic [7:0] ChLess    = 8'h3c;
  localparam logic [7:0] ChUpperM  = 8'h4d;
  localparam logic [7:0] ChLowerM  = 8'h6d;
  localparam logic [7:0] ChSemi    = 8'h3b;
  localparam logic [7:0] ChZero    = 8'h30;

  // register map
  localparam logic RegSgrMode = 1'b0;

  typedef logic [NumDigits-1:0][3:0] bcd_t;

  // one report ready for byte emission
  typedef struct packed {
    logic                                sgr;
    logic                                rel;
    logic [NumNums-1:0][BcdW-1:0]        bcd;
    logic [NumNums-1:0][DigitIdxW-1:0]   lead;
    logic [NumNums-1:0][CodeW-1:0]       bytes;
  } desc_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ESC,
    BK_BRACKET,
    BK_INTRO,
    BK_CODE,
    BK_SEMI1,
    BK_COL,
    BK_SEMI2,
    BK_ROW,
    BK_FINAL
  } back_state_e;

endpackage

@@ src/mre_front.sv @@
// front end: takes mouse events, forms the code, clamps and, in sgr mode, converts to decimal
`timescale 1ns / 1ps

module mre_front #(
  parameter int unsigned COORD_MAX = 4095
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sgr_mode_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [mre_pkg::ButtonW-1:0]   button_code_i,
  input  logic [mre_pkg::CoordW-1:0]    column_i,
  input  logic [mre_pkg::CoordW-1:0]    line_i,
  input  logic                          is_release_i,
  input  logic                          is_motion_i,
  input  logic [mre_pkg::ModW-1:0]      modifier_mask_i,
  output logic                          push_o,
  output mre_pkg::desc_t                desc_o,
  input  logic                          full_i
);

  // one double-dabble step: adjust digits, then shift in one bit
  function automatic logic [mre_pkg::BcdW-1:0] dd_step(input logic [mre_pkg::BcdW-1:0] bcd,
                                                       input logic bit_in);
    logic [mre_pkg::BcdW-1:0] adj;
    adj = bcd;
    for (int i = 0; i < mre_pkg::NumDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[mre_pkg::BcdW-2:0], bit_in};
  endfunction

  // index of the most significant nonzero digit, zero for the value zero
  function automatic logic [mre_pkg::DigitIdxW-1:0] lead_idx(
      input logic [mre_pkg::BcdW-1:0] bcd);
    logic [mre_pkg::DigitIdxW-1:0] idx;
    idx = '0;
    for (int i = 1; i < mre_pkg::NumDigits; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        idx = mre_pkg::DigitIdxW'(i);
      end
    end
    return idx;
  endfunction

  mre_pkg::front_state_e state_q, state_d;

  logic [mre_pkg::NumNums-1:0][mre_pkg::ConvW-1:0] src_q, src_d;
  logic [mre_pkg::NumNums-1:0][mre_pkg::BcdW-1:0]  bcd_q, bcd_d;
  logic [mre_pkg::ConvCntW-1:0]                    cnt_q, cnt_d;
  logic                                            sgr_q, rel_q;

  logic                       accept;
  logic                       conv_done;
  logic [mre_pkg::CodeW-1:0]  code;
  logic [mre_pkg::CoordW-1:0] col_sgr, row_sgr;
  logic [mre_pkg::CoordW-1:0] col_cls, row_cls;

  assign accept    = valid_i && ready_o;
  assign conv_done = (cnt_q == mre_pkg::ConvCntW'(mre_pkg::ConvW - 1));

  // event code and clamped coordinates
  always_comb begin
    code = {1'b0, button_code_i};
    if (is_motion_i) begin
      code = code + mre_pkg::MotionAdd;
    end
    if (modifier_mask_i[mre_pkg::ModShiftBit]) begin
      code = code + mre_pkg::ShiftAdd;
    end
    if (modifier_mask_i[mre_pkg::ModAltBit]) begin
      code = code + mre_pkg::AltAdd;
    end
    if (modifier_mask_i[mre_pkg::ModCtrlBit]) begin
      code = code + mre_pkg::CtrlAdd;
    end
    col_sgr = (32'(column_i) > COORD_MAX) ? mre_pkg::CoordW'(COORD_MAX) : column_i;
    row_sgr = (32'(line_i) > COORD_MAX) ? mre_pkg::CoordW'(COORD_MAX) : line_i;
    col_cls = (column_i > mre_pkg::ClassicClamp) ? mre_pkg::ClassicClamp : column_i;
    row_cls = (line_i > mre_pkg::ClassicClamp) ? mre_pkg::ClassicClamp : line_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mre_pkg::FR_IDLE: begin
        if (valid_i) begin
          state_d = sgr_mode_i ? mre_pkg::FR_CONV : mre_pkg::FR_PUSH;
        end
      end
      mre_pkg::FR_CONV: begin
        if (conv_done) begin
          state_d = mre_pkg::FR_PUSH;
        end
      end
      mre_pkg::FR_PUSH: begin
        if (!full_i) begin
          if (valid_i) begin
            state_d = sgr_mode_i ? mre_pkg::FR_CONV : mre_pkg::FR_PUSH;
          end else begin
            state_d = mre_pkg::FR_IDLE;
          end
        end
      end
      default: state_d = mre_pkg::FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ready_o = 1'b0;
    push_o  = 1'b0;
    case (state_q)
      mre_pkg::FR_IDLE: ready_o = 1'b1;
      mre_pkg::FR_PUSH: begin
        ready_o = !full_i;
        push_o  = !full_i;
      end
      default: begin
        ready_o = 1'b0;
        push_o  = 1'b0;
      end
    endcase
  end

  // payload: load on accept, shift during conversion
  always_comb begin
    src_d = src_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = '0;
      bcd_d = '0;
      if (sgr_mode_i) begin
        src_d[mre_pkg::NumCode] = {{(mre_pkg::ConvW - mre_pkg::CodeW){1'b0}}, code};
        src_d[mre_pkg::NumCol]  = {1'b0, col_sgr} + mre_pkg::ConvW'(1);
        src_d[mre_pkg::NumRow]  = {1'b0, row_sgr} + mre_pkg::ConvW'(1);
      end else begin
        src_d[mre_pkg::NumCode] = {{(mre_pkg::ConvW - mre_pkg::CodeW){1'b0}},
                                   code + mre_pkg::ClassicCodeOfs};
        src_d[mre_pkg::NumCol]  = {{(mre_pkg::ConvW - mre_pkg::CodeW){1'b0}},
                                   col_cls[mre_pkg::CodeW-1:0] + mre_pkg::ClassicCoordOfs};
        src_d[mre_pkg::NumRow]  = {{(mre_pkg::ConvW - mre_pkg::CodeW){1'b0}},
                                   row_cls[mre_pkg::CodeW-1:0] + mre_pkg::ClassicCoordOfs};
      end
    end else if (state_q == mre_pkg::FR_CONV) begin
      for (int n = 0; n < mre_pkg::NumNums; n++) begin
        bcd_d[n] = dd_step(bcd_q[n], src_q[n][mre_pkg::ConvW-1]);
        src_d[n] = {src_q[n][mre_pkg::ConvW-2:0], 1'b0};
      end
      cnt_d = cnt_q + mre_pkg::ConvCntW'(1);
    end
  end

  // report descriptor toward the queue
  always_comb begin
    desc_o.sgr = sgr_q;
    desc_o.rel = rel_q;
    desc_o.bcd = bcd_q;
    for (int n = 0; n < mre_pkg::NumNums; n++) begin
      desc_o.lead[n]  = lead_idx(bcd_q[n]);
      desc_o.bytes[n] = src_q[n][mre_pkg::CodeW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mre_pkg::FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    bcd_q <= bcd_d;
    if (accept) begin
      sgr_q <= sgr_mode_i;
      rel_q <= is_release_i;
    end
  end

endmodule

@@ src/mre_fifo.sv @@
// two-entry queue of report descriptors between front and back
`timescale 1ns / 1ps

module mre_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mre_pkg::desc_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output mre_pkg::desc_t pop_data_o,
  output logic           empty_o
);

  mre_pkg::desc_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2) else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

@@ src/mre_back.sv @@
// back end: walks a report descriptor and sends one byte per cycle while the receiver is ready
`timescale 1ns / 1ps

module mre_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  mre_pkg::desc_t desc_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [7:0]     byte_o,
  output logic           last_o
);

  mre_pkg::back_state_e state_q, state_d;
  logic [mre_pkg::DigitIdxW-1:0] dig_q, dig_d;
  mre_pkg::desc_t                cur_q;
  logic                          valid_q;
  logic [7:0]                    byte_q;
  logic                          last_q;

  logic       adv;
  logic       is_last;
  logic [7:0] byte_c;
  logic       dig_zero;

  assign adv      = (state_q != mre_pkg::BK_IDLE) && (!valid_q || ready_i);
  assign dig_zero = (dig_q == '0);
  assign is_last  = (state_q == mre_pkg::BK_FINAL) ||
                    (state_q == mre_pkg::BK_ROW && !cur_q.sgr);

  // next state and digit index
  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    pop_o   = 1'b0;
    case (state_q)
      mre_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = mre_pkg::BK_ESC;
        end
      end
      mre_pkg::BK_ESC: begin
        if (adv) begin
          state_d = mre_pkg::BK_BRACKET;
        end
      end
      mre_pkg::BK_BRACKET: begin
        if (adv) begin
          state_d = mre_pkg::BK_INTRO;
        end
      end
      mre_pkg::BK_INTRO: begin
        if (adv) begin
          state_d = mre_pkg::BK_CODE;
          dig_d   = cur_q.lead[mre_pkg::NumCode];
        end
      end
      mre_pkg::BK_CODE: begin
        if (adv) begin
          if (!cur_q.sgr) begin
            state_d = mre_pkg::BK_COL;
          end else if (dig_zero) begin
            state_d = mre_pkg::BK_SEMI1;
          end else begin
            dig_d = dig_q - mre_pkg::DigitIdxW'(1);
          end
        end
      end
      mre_pkg::BK_SEMI1: begin
        if (adv) begin
          state_d = mre_pkg::BK_COL;
          dig_d   = cur_q.lead[mre_pkg::NumCol];
        end
      end
      mre_pkg::BK_COL: begin
        if (adv) begin
          if (!cur_q.sgr) begin
            state_d = mre_pkg::BK_ROW;
          end else if (dig_zero) begin
            state_d = mre_pkg::BK_SEMI2;
          end else begin
            dig_d = dig_q - mre_pkg::DigitIdxW'(1);
          end
        end
      end
      mre_pkg::BK_SEMI2: begin
        if (adv) begin
          state_d = mre_pkg::BK_ROW;
          dig_d   = cur_q.lead[mre_pkg::NumRow];
        end
      end
      mre_pkg::BK_ROW, mre_pkg::BK_FINAL: begin
        if (adv) begin
          if (is_last) begin
            if (!empty_i) begin
              pop_o   = 1'b1;
              state_d = mre_pkg::BK_ESC;
            end else begin
              state_d = mre_pkg::BK_IDLE;
            end
          end else if (dig_zero) begin
            state_d = mre_pkg::BK_FINAL;
          end else begin
            dig_d = dig_q - mre_pkg::DigitIdxW'(1);
          end
        end
      end
      default: state_d = mre_pkg::BK_IDLE;
    endcase
  end

  // byte for the current position
  always_comb begin
    byte_c = 8'd0;
    case (state_q)
      mre_pkg::BK_ESC:     byte_c = mre_pkg::ChEsc;
      mre_pkg::BK_BRACKET: byte_c = mre_pkg::ChBracket;
      mre_pkg::BK_INTRO:   byte_c = cur_q.sgr ? mre_pkg::ChLess : mre_pkg::ChUpperM;
      mre_pkg::BK_CODE:    byte_c = cur_q.sgr ?
          (mre_pkg::ChZero + {4'd0, cur_q.bcd[mre_pkg::NumCode][4*dig_q +: 4]}) :
          cur_q.bytes[mre_pkg::NumCode];
      mre_pkg::BK_SEMI1,
      mre_pkg::BK_SEMI2:   byte_c = mre_pkg::ChSemi;
      mre_pkg::BK_COL:     byte_c = cur_q.sgr ?
          (mre_pkg::ChZero + {4'd0, cur_q.bcd[mre_pkg::NumCol][4*dig_q +: 4]}) :
          cur_q.bytes[mre_pkg::NumCol];
      mre_pkg::BK_ROW:     byte_c = cur_q.sgr ?
          (mre_pkg::ChZero + {4'd0, cur_q.bcd[mre_pkg::NumRow][4*dig_q +: 4]}) :
          cur_q.bytes[mre_pkg::NumRow];
      mre_pkg::BK_FINAL:   byte_c = cur_q.rel ? mre_pkg::ChLowerM : mre_pkg::ChUpperM;
      default:             byte_c = 8'd0;
    endcase
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mre_pkg::BK_IDLE;
      dig_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dig_q   <= dig_d;
      if (adv) begin
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // current report and output register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= desc_i;
    end
    if (adv) begin
      byte_q <= byte_c;
      last_q <= is_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == mre_pkg::BK_IDLE || (adv && is_last)))
    else $error("descriptor taken while a report is in progress");
  a_esc_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == mre_pkg::BK_ESC))
    else $error("report does not start with escape");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_last) |=> (state_q == mre_pkg::BK_ESC || state_q == mre_pkg::BK_IDLE))
    else $error("sequencer runs past the final byte");
`endif

endmodule

@@ src/mouse_report_encoder.sv @@
// top level: config register, event front end, descriptor queue, byte sequencer
// flow: classic requests go to the queue without conversion; sgr requests first pass a
//   bit-serial decimal conversion in the front end, which takes no new request meanwhile;
//   the output gives one byte per cycle while m_axis_tready holds, and an sgr report is
//   up to 17 bytes long
// reset: asynchronous active low, clears control state and selects classic mode
`timescale 1ns / 1ps

module mouse_report_encoder #(
  parameter int unsigned COORD_MAX = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] button_code, [18:7] column, [30:19] line, [38:31] modifier_mask
  input  logic [39:0] s_axis_tdata,
  // [0] is_release, [1] is_motion
  input  logic [1:0]  s_axis_tuser,
  // report bytes
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           sgr_mode_q;
  logic           push, full, pop, empty;
  mre_pkg::desc_t push_desc, pop_desc;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mre_pkg::RegSgrMode) ? {31'd0, sgr_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sgr_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mre_pkg::RegSgrMode) begin
      sgr_mode_q <= pwdata[0];
    end
  end

  // event front end
  mre_front #(
    .COORD_MAX(COORD_MAX)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sgr_mode_i     (sgr_mode_q),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .button_code_i  (s_axis_tdata[6:0]),
    .column_i       (s_axis_tdata[18:7]),
    .line_i         (s_axis_tdata[30:19]),
    .is_release_i   (s_axis_tuser[0]),
    .is_motion_i    (s_axis_tuser[1]),
    .modifier_mask_i(s_axis_tdata[38:31]),
    .push_o         (push),
    .desc_o         (push_desc),
    .full_i         (full)
  );

  // descriptor queue
  mre_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_desc),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_desc),
    .empty_o    (empty)
  );

  // byte sequencer
  mre_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .desc_i (pop_desc),
    .pop_o  (pop),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .byte_o (m_axis_tdata),
    .last_o (m_axis_tlast)
  );

endmodule

@@ dv/mouse_report_checker.sv @@
// report checker for the mouse report encoder: tracks the mode, predicts bytes, compares
`timescale 1ns / 1ps

module mouse_report_checker #(
  parameter int unsigned COORD_MAX = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count,
  output int          bytes_checked
);

  localparam logic [2:0] SgrModeAddr = 3'(4 * int'(mre_pkg::RegSgrMode));
  localparam int         MaxReported = 10;

  // characters of a report
  localparam logic [7:0] AsciiEsc     = 8'h1b;
  localparam logic [7:0] AsciiLbrack  = 8'h5b;
  localparam logic [7:0] AsciiLess    = 8'h3c;
  localparam logic [7:0] AsciiSemi    = 8'h3b;
  localparam logic [7:0] AsciiUpperM  = 8'h4d;
  localparam logic [7:0] AsciiLowerM  = 8'h6d;
  localparam logic [7:0] AsciiZero    = 8'h30;
  localparam int unsigned ClassicMax  = 222;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } report_byte_t;

  report_byte_t expected_report_bytes[$];
  logic [7:0]   report_bytes[$];
  logic         sgr_mode_q;
  int           errors;
  int           checked;

  // digits of a number, most significant first, no leading zeros
  function automatic void append_decimal(input int unsigned value);
    logic [7:0]  digits[$];
    int unsigned v = value;
    do begin
      digits.push_front(8'(int'(AsciiZero) + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[k]) report_bytes.push_back(digits[k]);
  endfunction

  // whole report for one mouse event under the current mode
  function automatic void predict_report(input logic [39:0] data, input logic [1:0] user);
    logic [6:0]  button;
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  mods;
    logic        rel_flag;
    logic        motion_flag;
    int unsigned code;
    int unsigned col_v;
    int unsigned row_v;
    button      = data[6:0];
    col         = data[18:7];
    row         = data[30:19];
    mods        = data[38:31];
    rel_flag    = user[0];
    motion_flag = user[1];
    code = button;
    if (motion_flag) code += 32;
    if (mods[0]) code += 4;
    if (mods[3]) code += 8;
    if (mods[2]) code += 16;
    col_v = col;
    row_v = row;
    report_bytes.delete();
    report_bytes.push_back(AsciiEsc);
    report_bytes.push_back(AsciiLbrack);
    if (sgr_mode_q) begin
      if (col_v > COORD_MAX) col_v = COORD_MAX;
      if (row_v > COORD_MAX) row_v = COORD_MAX;
      report_bytes.push_back(AsciiLess);
      append_decimal(code);
      report_bytes.push_back(AsciiSemi);
      append_decimal(col_v + 1);
      report_bytes.push_back(AsciiSemi);
      append_decimal(row_v + 1);
      report_bytes.push_back(rel_flag ? AsciiLowerM : AsciiUpperM);
    end else begin
      // release flag has no effect in classic encoding
      if (col_v > ClassicMax) col_v = ClassicMax;
      if (row_v > ClassicMax) row_v = ClassicMax;
      report_bytes.push_back(AsciiUpperM);
      report_bytes.push_back(8'(code + 32));
      report_bytes.push_back(8'(col_v + 33));
      report_bytes.push_back(8'(row_v + 33));
    end
    foreach (report_bytes[k])
      expected_report_bytes.push_back('{report_bytes[k], k == report_bytes.size() - 1});
  endfunction

  // compare outgoing bytes, predict on accepted requests, follow register writes
  always @(posedge clk_i or negedge rst_ni) begin
    report_byte_t want;
    if (!rst_ni) begin
      expected_report_bytes.delete();
      sgr_mode_q = 1'b0;
      errors     = 0;
      checked    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_report_bytes.size() == 0) begin
          errors++;
          if (errors <= MaxReported)
            $display("%0t: unexpected report byte %02h last %0b with nothing pending",
                     $realtime, m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_report_bytes.pop_front();
          if (want.value !== m_axis_tdata || want.last !== m_axis_tlast) begin
            errors++;
            if (errors <= MaxReported)
              $display("%0t: report byte mismatch: expected %02h last %0b, got %02h last %0b",
                       $realtime, want.value, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
        checked++;
      end
      if (s_axis_tvalid && s_axis_tready) predict_report(s_axis_tdata, s_axis_tuser);
      if (psel && penable && pwrite && pready && paddr == SgrModeAddr)
        sgr_mode_q = pwdata[0];
    end
    fail_count    <= errors;
    pending_count <= expected_report_bytes.size();
    bytes_checked <= checked;
  end

endmodule

@@ dv/mouse_report_encoder_tb.sv @@
// testbench top for the mouse report encoder: stimulus, flow control and verdict
`timescale 1ns / 1ps

module mouse_report_encoder_tb;

  localparam int WatchdogLimit  = 3000;
  localparam int DrainCycles    = 32;
  localparam int HoldOffCycles  = 400;
  localparam int RandomPhases   = 8;
  localparam int ItemsPerPhase  = 14;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [6:0] button_code, [18:7] column, [30:19] line, [38:31] modifier_mask
  logic [39:0] s_axis_tdata = '0;
  // [0] is_release, [1] is_motion
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_count;
  int bytes_checked;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int events_sent = 0;
  int directed_events = 0;
  int idle_cycles = 0;
  bit hold_off_req = 1'b0;

  mouse_report_encoder uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mouse_report_checker report_check (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending_count, .bytes_checked
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        hold_off_req  <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one mouse event request, with random idle cycles ahead of it
  task automatic send_event(input logic [6:0] button, input logic [11:0] col,
                            input logic [11:0] row, input logic rel_flag,
                            input logic motion_flag, input logic [7:0] mods);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, mods, row, col, button};
    s_axis_tuser  <= {motion_flag, rel_flag};
    do @(posedge clk_i); while (!s_axis_tready);
    events_sent++;
  endtask

  // coordinates spread over small, clamp-edge, mid and full range
  function automatic logic [11:0] random_coord();
    case ($urandom_range(3))
      0:       return 12'($urandom);
      1:       return 12'($urandom_range(230, 215));
      2:       return 12'($urandom_range(15));
      default: return 12'($urandom_range(999));
    endcase
  endfunction

  task automatic send_random_event();
    logic [6:0] button;
    if ($urandom_range(1)) begin
      case ($urandom_range(5))
        0: button = 7'd0;
        1: button = 7'd1;
        2: button = 7'd2;
        3: button = 7'd3;
        4: button = 7'd64;
        default: button = 7'd65;
      endcase
    end else begin
      button = 7'($urandom);
    end
    send_event(button, random_coord(), random_coord(), 1'($urandom), 1'($urandom),
               8'($urandom));
  endtask

  // stop offering and wait until every expected byte has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  // mode change only while the block is idle
  task automatic set_mode(input logic sgr);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(mre_pkg::RegSgrMode));
    pwdata  <= {31'($urandom), sgr};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // main sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // classic encoding after reset: clamp edges, buttons, modifiers
    send_event(7'd0,   12'd0,    12'd0,    1'b0, 1'b0, 8'h00);
    send_event(7'd1,   12'd222,  12'd221,  1'b0, 1'b0, 8'h00);
    send_event(7'd2,   12'd223,  12'd4095, 1'b0, 1'b0, 8'h00);
    send_event(7'd3,   12'd4095, 12'd222,  1'b0, 1'b1, 8'h00);
    send_event(7'd64,  12'd100,  12'd50,   1'b0, 1'b0, 8'h01);
    send_event(7'd65,  12'd10,   12'd20,   1'b0, 1'b0, 8'h04);
    // release is not encoded in classic mode
    send_event(7'd0,   12'd5,    12'd6,    1'b1, 1'b0, 8'h08);
    send_event(7'd127, 12'd4095, 12'd4095, 1'b1, 1'b1, 8'hff);
    send_event(7'd1,   12'd7,    12'd7,    1'b0, 1'b0, 8'hf2);

    // sgr encoding: digit count changes, release final, largest values
    set_mode(1'b1);
    send_event(7'd0,   12'd0,    12'd0,    1'b0, 1'b0, 8'h00);
    send_event(7'd2,   12'd8,    12'd9,    1'b1, 1'b0, 8'h00);
    send_event(7'd127, 12'd4095, 12'd4095, 1'b1, 1'b1, 8'hff);
    send_event(7'd3,   12'd98,   12'd99,   1'b0, 1'b1, 8'h05);
    send_event(7'd64,  12'd998,  12'd999,  1'b0, 1'b0, 8'h08);
    send_event(7'd65,  12'd4094, 12'd1234, 1'b1, 1'b0, 8'h0d);
    send_event(7'd1,   12'd222,  12'd223,  1'b0, 1'b0, 8'hf2);
    send_event(7'd10,  12'd99,   12'd9,    1'b0, 1'b0, 8'h01);
    send_event(7'd100, 12'd1,    12'd3000, 1'b1, 1'b1, 8'h00);
    directed_events = events_sent;

    // random events, alternating modes over the idling phases
    for (int phase = 0; phase < RandomPhases; phase++) begin
      set_mode(phase % 2 == 1);
      case (phase / 2)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      // long receiver hold-off while requests keep coming, so the input backs up
      if (phase == 0) hold_off_req <= 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (phase == 5 && n == ItemsPerPhase / 2) wait_drained();
        send_random_event();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d mouse events (%0d directed, %0d random) in classic and sgr mode",
             events_sent, directed_events, events_sent - directed_events);
    $display("%0d report bytes compared, %0d bad, under four idling mixes",
             bytes_checked, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/mre_pkg.sv
src/mre_front.sv
src/mre_fifo.sv
src/mre_back.sv
src/mouse_report_encoder.sv
dv/mouse_report_checker.sv
dv/mouse_report_encoder_tb.sv
